[src/qvr_pkg.sv]
// Shared types and constants of the quaternion vector rotation block.
`default_nettype none
package qvr_pkg;

  localparam int unsigned VEC_W     = 16;
  localparam int unsigned QUAT_W    = 16;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [QUAT_W-1:0] QUAT_W_RST = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_X = 3'd0,
    REG_QUAT_Y = 3'd1,
    REG_QUAT_Z = 3'd2,
    REG_QUAT_W = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } quat_t;

  // Per-item side information that travels next to the arithmetic.
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } side_t;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             zero;
  } res_t;

endpackage
`default_nettype wire

[src/qvr_norm.sv]
// Squares, squared length and pipelined restoring division of each v^2 by the squared length.
`default_nettype none
module qvr_norm #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic signed [qvr_pkg::VEC_W-1:0]     vec_x_i,
  input  wire logic signed [qvr_pkg::VEC_W-1:0]     vec_y_i,
  input  wire logic signed [qvr_pkg::VEC_W-1:0]     vec_z_i,
  output logic             [2*FRAC_BITS:0]          quo_o [3],
  output qvr_pkg::side_t                            side_o
);

  localparam int unsigned QW     = 2 * FRAC_BITS + 1;
  localparam int unsigned DIV_ST = 2 * FRAC_BITS + 1;
  localparam int unsigned SQ_W   = 2 * qvr_pkg::VEC_W - 1;
  localparam int unsigned S_W    = 2 * qvr_pkg::VEC_W;
  localparam int unsigned RW     = S_W + 1;

  logic signed [qvr_pkg::VEC_W-1:0] vin [3];
  logic signed [S_W-1:0]            sqp [3];

  logic [SQ_W-1:0] sq_a_q [3];
  logic [2:0]      neg_a_q;
  logic [SQ_W-1:0] sq_b_q [3];
  logic [S_W-1:0]  s_b_q;
  qvr_pkg::side_t  sd_b_q;
  logic [S_W-1:0]  s_d;

  logic [RW-1:0]   r_q  [DIV_ST][3];
  logic [QW-1:0]   qt_q [DIV_ST][3];
  logic [S_W-1:0]  s_q  [DIV_ST];
  qvr_pkg::side_t  sd_q [DIV_ST];

  assign vin[0] = vec_x_i;
  assign vin[1] = vec_y_i;
  assign vin[2] = vec_z_i;

  for (genvar l = 0; l < 3; l++) begin : g_sq
    assign sqp[l] = vin[l] * vin[l];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_a_q[l]  <= sqp[l][SQ_W-1:0];
        neg_a_q[l] <= vin[l][qvr_pkg::VEC_W-1];
        sq_b_q[l]  <= sq_a_q[l];
      end
    end
  end

  assign s_d = S_W'(sq_a_q[0]) + S_W'(sq_a_q[1]) + S_W'(sq_a_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_b_q       <= s_d;
      sd_b_q.neg  <= neg_a_q;
      sd_b_q.zero <= (s_d == '0);
    end
  end

  // One quotient bit per stage; the first stage yields the integer bit.
  for (genvar k = 0; k < DIV_ST; k++) begin : g_div
    logic [S_W-1:0] s_in;
    qvr_pkg::side_t sd_in;
    if (k == 0) begin : g_first
      assign s_in  = s_b_q;
      assign sd_in = sd_b_q;
    end else begin : g_next
      assign s_in  = s_q[k-1];
      assign sd_in = sd_q[k-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RW-1:0] r_sh;
      logic [QW-1:0] q_sh;
      logic          ge;
      if (k == 0) begin : g_first
        assign r_sh = RW'(sq_b_q[l]);
        assign q_sh = '0;
      end else begin : g_next
        assign r_sh = {r_q[k-1][l][RW-2:0], 1'b0};
        assign q_sh = {qt_q[k-1][l][QW-2:0], 1'b0};
      end
      assign ge = (r_sh >= {1'b0, s_in});
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k][l]  <= ge ? (r_sh - {1'b0, s_in}) : r_sh;
          qt_q[k][l] <= q_sh | QW'(ge);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k]  <= s_in;
        sd_q[k] <= sd_in;
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = qt_q[DIV_ST-1][l];
  end
  assign side_o = sd_q[DIV_ST-1];

endmodule
`default_nettype wire

[src/qvr_isqrt.sv]
// Pipelined integer square root, one result bit per stage, for three lanes.
`default_nettype none
module qvr_isqrt #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic        [2*FRAC_BITS:0] rad_i [3],
  input  wire qvr_pkg::side_t              side_i,
  output logic             [FRAC_BITS:0]   root_o [3],
  output qvr_pkg::side_t                   side_o
);

  localparam int unsigned NW    = 2 * FRAC_BITS + 1;
  localparam int unsigned RSW   = NW + 1;
  localparam int unsigned SQ_ST = FRAC_BITS + 1;

  logic [NW-1:0]  n_q   [SQ_ST][3];
  logic [RSW-1:0] res_q [SQ_ST][3];
  qvr_pkg::side_t sd_q  [SQ_ST];

  for (genvar j = 0; j < SQ_ST; j++) begin : g_st
    localparam logic [RSW-1:0] BIT = RSW'(1) << (2 * (FRAC_BITS - j));
    qvr_pkg::side_t sd_in;
    if (j == 0) begin : g_first
      assign sd_in = side_i;
    end else begin : g_next
      assign sd_in = sd_q[j-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [NW-1:0]  n_in;
      logic [RSW-1:0] res_in;
      logic [RSW-1:0] sum;
      logic           ge;
      if (j == 0) begin : g_first
        assign n_in   = rad_i[l];
        assign res_in = '0;
      end else begin : g_next
        assign n_in   = n_q[j-1][l];
        assign res_in = res_q[j-1][l];
      end
      assign sum = res_in + BIT;
      assign ge  = ({1'b0, n_in} >= sum);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[j][l]   <= ge ? NW'({1'b0, n_in} - sum) : n_in;
          res_q[j][l] <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[j] <= sd_in;
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign root_o[l] = res_q[SQ_ST-1][l][FRAC_BITS:0];
  end
  assign side_o = sd_q[SQ_ST-1];

endmodule
`default_nettype wire

[src/qvr_rotate.sv]
// Two Hamilton products q * v * conj(q) in four stages, with rounding and saturation.
`default_nettype none
module qvr_rotate #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic        [FRAC_BITS:0] root_i [3],
  input  wire qvr_pkg::side_t            side_i,
  input  wire qvr_pkg::quat_t            quat_i,
  output qvr_pkg::res_t                  res_o
);

  localparam int unsigned AW  = FRAC_BITS + 2;
  localparam int unsigned P1W = AW + qvr_pkg::QUAT_W;
  localparam int unsigned SW1 = P1W + 2;
  localparam int unsigned TW  = 19;
  localparam int unsigned P2W = TW + qvr_pkg::QUAT_W;
  localparam int unsigned SW2 = P2W + 2;

  localparam logic signed [SW1-1:0] RND1    = SW1'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW2-1:0] RND2    = SW2'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW2-1:0] SAT_MAX = SW2'(32767);
  localparam logic signed [SW2-1:0] SAT_MIN = -SW2'(32768);

  logic signed [AW-1:0] a, b, c;

  logic signed [P1W-1:0] aw_q, bz_q, cy_q, bw_q, cx_q, az_q;
  logic signed [P1W-1:0] cw_q, ay_q, bx_q, ax_q, by_q, cz_q;
  logic signed [SW1-1:0] s_tx, s_ty, s_tz, s_tw;
  logic signed [SW1-1:0] h_tx, h_ty, h_tz, h_tw;
  logic signed [TW-1:0]  tx_q, ty_q, tz_q, tw_q;
  logic signed [P2W-1:0] wtx_q, xtw_q, ytz_q, zty_q;
  logic signed [P2W-1:0] wty_q, ytw_q, ztx_q, xtz_q;
  logic signed [P2W-1:0] wtz_q, ztw_q, xty_q, ytx_q;
  logic signed [SW2-1:0] s_rx, s_ry, s_rz;
  logic signed [SW2-1:0] h_rx, h_ry, h_rz;
  qvr_pkg::side_t        sd1_q, sd2_q, sd3_q;
  qvr_pkg::res_t         res_q;

  function automatic logic [qvr_pkg::OUT_W-1:0] sat(input logic signed [SW2-1:0] v);
    logic [qvr_pkg::OUT_W-1:0] o;
    if (v > SAT_MAX) begin
      o = 16'h7fff;
    end else if (v < SAT_MIN) begin
      o = 16'h8000;
    end else begin
      o = v[qvr_pkg::OUT_W-1:0];
    end
    return o;
  endfunction

  assign a = side_i.neg[0] ? -$signed({1'b0, root_i[0]}) : $signed({1'b0, root_i[0]});
  assign b = side_i.neg[1] ? -$signed({1'b0, root_i[1]}) : $signed({1'b0, root_i[1]});
  assign c = side_i.neg[2] ? -$signed({1'b0, root_i[2]}) : $signed({1'b0, root_i[2]});

  // Stage 1: products of the unit vector with the quaternion.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aw_q  <= a * quat_i.w;
      bz_q  <= b * quat_i.z;
      cy_q  <= c * quat_i.y;
      bw_q  <= b * quat_i.w;
      cx_q  <= c * quat_i.x;
      az_q  <= a * quat_i.z;
      cw_q  <= c * quat_i.w;
      ay_q  <= a * quat_i.y;
      bx_q  <= b * quat_i.x;
      ax_q  <= a * quat_i.x;
      by_q  <= b * quat_i.y;
      cz_q  <= c * quat_i.z;
      sd1_q <= side_i;
    end
  end

  // Stage 2: t = v * conj(q), rounded back to the fractional scale.
  assign s_tx = aw_q - bz_q + cy_q + RND1;
  assign s_ty = bw_q - cx_q + az_q + RND1;
  assign s_tz = cw_q - ay_q + bx_q + RND1;
  assign s_tw = ax_q + by_q + cz_q + RND1;
  assign h_tx = s_tx >>> FRAC_BITS;
  assign h_ty = s_ty >>> FRAC_BITS;
  assign h_tz = s_tz >>> FRAC_BITS;
  assign h_tw = s_tw >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx_q  <= h_tx[TW-1:0];
      ty_q  <= h_ty[TW-1:0];
      tz_q  <= h_tz[TW-1:0];
      tw_q  <= h_tw[TW-1:0];
      sd2_q <= sd1_q;
    end
  end

  // Stage 3: products of q with t.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wtx_q <= quat_i.w * tx_q;
      xtw_q <= quat_i.x * tw_q;
      ytz_q <= quat_i.y * tz_q;
      zty_q <= quat_i.z * ty_q;
      wty_q <= quat_i.w * ty_q;
      ytw_q <= quat_i.y * tw_q;
      ztx_q <= quat_i.z * tx_q;
      xtz_q <= quat_i.x * tz_q;
      wtz_q <= quat_i.w * tz_q;
      ztw_q <= quat_i.z * tw_q;
      xty_q <= quat_i.x * ty_q;
      ytx_q <= quat_i.y * tx_q;
      sd3_q <= sd2_q;
    end
  end

  // Stage 4: vector part of q * t, rounded and saturated.
  assign s_rx = wtx_q + xtw_q + ytz_q - zty_q + RND2;
  assign s_ry = wty_q + ytw_q + ztx_q - xtz_q + RND2;
  assign s_rz = wtz_q + ztw_q + xty_q - ytx_q + RND2;
  assign h_rx = s_rx >>> FRAC_BITS;
  assign h_ry = s_ry >>> FRAC_BITS;
  assign h_rz = s_rz >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.x    <= sd3_q.zero ? '0 : sat(h_rx);
      res_q.y    <= sd3_q.zero ? '0 : sat(h_ry);
      res_q.z    <= sd3_q.zero ? '0 : sat(h_rz);
      res_q.zero <= sd3_q.zero;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

[src/quaternion_vector_rotate_top.sv]
// Top level of the quaternion vector rotation pipeline.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | vec_x_i, vec_y_i, vec_z_i
//   out     | output    | out_valid_o / out_stall_i| rot_x_o, rot_y_o, rot_z_o, zero_length_o
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One vector enters per cycle while the skid register is empty and in_stall_o is low.
// The pipeline is made of the restoring divider (2*FRAC_BITS+1 stages) and the square root
// (FRAC_BITS+1 stages), one bit per stage, plus squaring and the two quaternion products.
// Reset clears the valid bits, including those of the output and skid registers, and sets the identity rotation.
// A stalled result waits in the output register and one more goes into a skid register;
// the pipeline freezes only while the skid register is full.
`default_nettype none
module quaternion_vector_rotate_top #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [qvr_pkg::VEC_W-1:0]       vec_x_i,
  input  wire logic signed [qvr_pkg::VEC_W-1:0]       vec_y_i,
  input  wire logic signed [qvr_pkg::VEC_W-1:0]       vec_z_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed      [qvr_pkg::OUT_W-1:0]       rot_x_o,
  output logic signed      [qvr_pkg::OUT_W-1:0]       rot_y_o,
  output logic signed      [qvr_pkg::OUT_W-1:0]       rot_z_o,
  output logic                                        zero_length_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic        [qvr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic        [qvr_pkg::QUAT_W-1:0]      cfg_data_i
);

  localparam int unsigned N = 3 * FRAC_BITS + 8;

  qvr_pkg::quat_t quat_q;
  logic [N-1:0]   v_q;
  logic           en;
  logic           arr;

  logic           [2*FRAC_BITS:0] quo [3];
  logic           [FRAC_BITS:0]   root [3];
  qvr_pkg::side_t                 sd_norm, sd_sqrt;
  qvr_pkg::res_t                  res;

  logic           ov_q, ov_d, sk_v_q, sk_v_d;
  qvr_pkg::res_t  od_q, od_d, sk_q, sk_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
      quat_q.w <= qvr_pkg::QUAT_W_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (qvr_pkg::cfg_reg_e'(cfg_index_i))
        qvr_pkg::REG_QUAT_X: quat_q.x <= cfg_data_i;
        qvr_pkg::REG_QUAT_Y: quat_q.y <= cfg_data_i;
        qvr_pkg::REG_QUAT_Z: quat_q.z <= cfg_data_i;
        qvr_pkg::REG_QUAT_W: quat_q.w <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en         = !sk_v_q;
  assign in_stall_o = sk_v_q;
  assign arr        = en && v_q[N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-2:0], in_valid_i};
    end
  end

  qvr_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk_i   (clk_i),
    .en_i    (en),
    .vec_x_i (vec_x_i),
    .vec_y_i (vec_y_i),
    .vec_z_i (vec_z_i),
    .quo_o   (quo),
    .side_o  (sd_norm)
  );

  qvr_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (quo),
    .side_i (sd_norm),
    .root_o (root),
    .side_o (sd_sqrt)
  );

  qvr_rotate #(.FRAC_BITS(FRAC_BITS)) u_rotate (
    .clk_i  (clk_i),
    .en_i   (en),
    .root_i (root),
    .side_i (sd_sqrt),
    .quat_i (quat_q),
    .res_o  (res)
  );

  // Output register with a one-entry skid behind it.
  always_comb begin
    ov_d   = ov_q;
    sk_v_d = sk_v_q;
    od_d   = od_q;
    sk_d   = sk_q;
    if (sk_v_q) begin
      if (!out_stall_i) begin
        od_d   = sk_q;
        sk_v_d = 1'b0;
      end
    end else if (!ov_q || !out_stall_i) begin
      ov_d = arr;
      if (arr) begin
        od_d = res;
      end
    end else if (arr) begin
      sk_v_d = 1'b1;
      sk_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      ov_q   <= ov_d;
      sk_v_q <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    sk_q <= sk_d;
  end

  assign out_valid_o   = ov_q;
  assign rot_x_o       = od_q.x;
  assign rot_y_o       = od_q.y;
  assign rot_z_o       = od_q.z;
  assign zero_length_o = od_q.zero;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> ov_q)
    else $error("skid entry held without a pending output transaction");

  a_zero_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_length_o) |-> (rot_x_o == '0 && rot_y_o == '0 && rot_z_o == '0))
    else $error("zero-length transaction with nonzero result");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(out_valid_o && out_stall_i))
    else $error("skid filled while the output was free");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sk_v_q && !out_stall_i) |=> (out_valid_o && !sk_v_q))
    else $error("skid entry not moved to the output");

endmodule
`default_nettype wire

[sim/quaternion_vector_rotate_checker.sv]
// Checker that predicts rotated vectors and compares them with the block's results.
`timescale 1ns / 100ps
module quaternion_vector_rotate_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [qvr_pkg::VEC_W-1:0]    vec_x_i,
  input  logic signed [qvr_pkg::VEC_W-1:0]    vec_y_i,
  input  logic signed [qvr_pkg::VEC_W-1:0]    vec_z_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [qvr_pkg::OUT_W-1:0]    rot_x_i,
  input  logic signed [qvr_pkg::OUT_W-1:0]    rot_y_i,
  input  logic signed [qvr_pkg::OUT_W-1:0]    rot_z_i,
  input  logic                                zero_length_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic        [qvr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [qvr_pkg::QUAT_W-1:0]   cfg_data_i,
  output int                                  pending_o,
  output int                                  fails_o
);

  localparam int FRAC = 14;

  qvr_pkg::quat_t orient;
  qvr_pkg::res_t  rot_queue[$];
  int             fails;

  initial begin
    pending_o = 0;
    fails_o   = 0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Truncated toward zero: sign(v) * floor(|v| * 2^F / sqrt(s)).
  function automatic longint unit_scale(longint v, longint unsigned s);
    longint unsigned sq;
    longint          m;
    sq = longint'(v * v);
    m  = longint'(int_sqrt((sq << (2 * FRAC)) / s));
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint round_frac(longint n);
    return (n + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic logic [qvr_pkg::OUT_W-1:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[qvr_pkg::OUT_W-1:0];
  endfunction

  function automatic qvr_pkg::res_t rotate_vector(longint vx, longint vy, longint vz,
                                                  qvr_pkg::quat_t q);
    longint unsigned s;
    longint a, b, c, x, y, z, w, tx, ty, tz, tw;
    qvr_pkg::res_t r;
    s = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
    r = '0;
    if (s == 0) begin
      r.zero = 1'b1;
      return r;
    end
    x = q.x;
    y = q.y;
    z = q.z;
    w = q.w;
    a = unit_scale(vx, s);
    b = unit_scale(vy, s);
    c = unit_scale(vz, s);
    // First product with the conjugate, then the product with q itself.
    tx = round_frac(a * w - b * z + c * y);
    ty = round_frac(b * w - c * x + a * z);
    tz = round_frac(c * w - a * y + b * x);
    tw = round_frac(a * x + b * y + c * z);
    r.x = clamp16(round_frac(w * tx + x * tw + y * tz - z * ty));
    r.y = clamp16(round_frac(w * ty + y * tw + z * tx - x * tz));
    r.z = clamp16(round_frac(w * tz + z * tw + x * ty - y * tx));
    return r;
  endfunction

  // Handshakes are sampled at the falling edge, where every signal is settled.
  always @(negedge clk_i or negedge rst_ni) begin
    qvr_pkg::res_t want;
    if (!rst_ni) begin
      orient   = '0;
      orient.w = qvr_pkg::QUAT_W_RST;
      rot_queue.delete();
      fails    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          qvr_pkg::REG_QUAT_X: orient.x = cfg_data_i;
          qvr_pkg::REG_QUAT_Y: orient.y = cfg_data_i;
          qvr_pkg::REG_QUAT_Z: orient.z = cfg_data_i;
          qvr_pkg::REG_QUAT_W: orient.w = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        rot_queue.push_back(rotate_vector(vec_x_i, vec_y_i, vec_z_i, orient));
      if (out_valid_i && !out_stall_i) begin
        if (rot_queue.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result transaction: expected none, got %0d %0d %0d z=%0b",
                     rot_x_i, rot_y_i, rot_z_i, zero_length_i);
        end else begin
          want = rot_queue.pop_front();
          if (want.x !== rot_x_i || want.y !== rot_y_i || want.z !== rot_z_i ||
              want.zero !== zero_length_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected %0d %0d %0d z=%0b, got %0d %0d %0d z=%0b",
                       $signed(want.x), $signed(want.y), $signed(want.z), want.zero,
                       rot_x_i, rot_y_i, rot_z_i, zero_length_i);
          end
        end
      end
    end
    pending_o = rot_queue.size();
    fails_o   = fails;
  end
endmodule

[sim/quaternion_vector_rotate_top_tb.sv]
// Testbench top: stimulus, stall patterns and verdict for the rotation block.
`timescale 1ns / 100ps
module quaternion_vector_rotate_top_tb;

  localparam int LATENCY = 60;
  localparam int LIMIT   = 600000;
  localparam logic [qvr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [qvr_pkg::VEC_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [qvr_pkg::OUT_W-1:0] rot_x, rot_y, rot_z;
  logic zero_length;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qvr_pkg::QUAT_W-1:0] cfg_data = '0;
  int pending, fails;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int hold_cnt = 0;
  logic hold_go = 1'b0;

  always #10 clk = ~clk;

  quaternion_vector_rotate_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .rot_x_o(rot_x), .rot_y_o(rot_y), .rot_z_o(rot_z), .zero_length_o(zero_length),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  quaternion_vector_rotate_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .rot_x_i(rot_x), .rot_y_i(rot_y), .rot_z_i(rot_z), .zero_length_i(zero_length),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pending_o(pending), .fails_o(fails)
  );

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_vec(input logic [qvr_pkg::VEC_W-1:0] x, y, z);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic cfg_write(input logic [qvr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qvr_pkg::QUAT_W-1:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic set_orient(input int qx, qy, qz, qw);
    cfg_write(qvr_pkg::REG_QUAT_X, qx[qvr_pkg::QUAT_W-1:0]);
    cfg_write(qvr_pkg::REG_QUAT_Y, qy[qvr_pkg::QUAT_W-1:0]);
    cfg_write(qvr_pkg::REG_QUAT_Z, qz[qvr_pkg::QUAT_W-1:0]);
    cfg_write(qvr_pkg::REG_QUAT_W, qw[qvr_pkg::QUAT_W-1:0]);
    // A write to an unused index must leave the rotation alone.
    cfg_write(REG_UNUSED, 16'h7fff);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [qvr_pkg::VEC_W-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15) - 8;
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      2: return $urandom_range(0, 511) - 256;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_q();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed vectors under the identity rotation left by reset.
    send_vec(0, 0, 0);
    send_vec(1, 0, 0);
    send_vec(0, 1, 0);
    send_vec(0, 0, 1);
    send_vec(-1, 0, 0);
    send_vec(16'h8000, 16'h8000, 16'h8000);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff);
    send_vec(16'h8000, 16'h7fff, 0);
    send_vec(3, 4, 0);
    send_vec(1, 1, 1);
    drain();
    // A half turn about x and a quarter turn about z.
    set_orient(16384, 0, 0, 0);
    send_vec(0, 1, 0);
    send_vec(16'h8000, 16'h7fff, 16'h8000);
    send_vec(0, 0, 0);
    drain();
    set_orient(0, 0, 11585, 11585);
    send_vec(1, 0, 0);
    send_vec(0, 16'h8000, 0);
    drain();
    // Non-unit extremes drive the output into saturation.
    set_orient(16384, 16384, 16384, 16384);
    send_vec(16'h7fff, 16'h7fff, 16'h7fff);
    send_vec(1, -1, 1);
    drain();
    set_orient(-16384, -16384, -16384, -16384);
    send_vec(16'h8000, 0, 16'h7fff);
    send_vec(-1, -1, -1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_orient(16384, -16384, 16384, -16384);
        1: set_orient(0, 0, 0, 16384);
        default: set_orient(rand_q(), rand_q(), rand_q(), rand_q());
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      if (ph == 4) hold_go = 1'b1;
      for (int n = 0; n < 155; n++) begin
        if (ph == 5 && n == 80) begin
          // The sender waits for every outstanding result before going on.
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        if ($urandom_range(0, 49) == 0) send_vec(0, 0, 0);
        else send_vec(rand_comp(), rand_comp(), rand_comp());
      end
      drain();
    end

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[quaternion_vector_rotate_top.f]
src/qvr_pkg.sv
src/qvr_norm.sv
src/qvr_isqrt.sv
src/qvr_rotate.sv
src/quaternion_vector_rotate_top.sv
sim/quaternion_vector_rotate_checker.sv
sim/quaternion_vector_rotate_top_tb.sv
